>>> src/skfk_pkg.sv
// ----------------------------------------------------------------------------
// skfk_pkg
// Shared types and constants of the skeleton forward kinematics core.
// ----------------------------------------------------------------------------
package skfk_pkg;

  localparam logic [7:0]         ROOT_MARK = 8'd255;
  localparam logic signed [15:0] Q_ONE     = 16'sd16384;

  typedef enum logic [2:0] {
    OP_CLEAR    = 3'd0,
    OP_LOAD     = 3'd1,
    OP_COUNT    = 3'd2,
    OP_ORIENT   = 3'd3,
    OP_SOLVE    = 3'd4,
    OP_READ     = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_REJECTED  = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]  parent;
    logic [7:0]  node;
    logic [15:0] len;
  } bone_t;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } pos_t;

  typedef struct packed {
    quat_t q;
    pos_t  p;
  } joint_t;

endpackage

>>> src/skeleton_forward_kinematics_core.sv
// ----------------------------------------------------------------------------
// skeleton_forward_kinematics_core
// Bone table, node orientations and joint poses with a forward solve.
// ----------------------------------------------------------------------------
// Clear, load and set count finish in the execute state; read joint reads the
// pose memory first; set orientation scans the bones in order; solve walks the
// bones in order and sends each child bone through the one rotation unit.
// One transaction is in progress at a time; a finished result waits in the
// output register while the next transaction is taken.
// Synchronous active-low reset: empty table, identity orientations, zero poses.
module skeleton_forward_kinematics_core #(
  parameter int BONE_SLOTS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_opcode,
  input  logic [7:0]         in_bone_index,
  input  logic [7:0]         in_bone_count,
  input  logic [7:0]         in_parent_index,
  input  logic [7:0]         in_node_id,
  input  logic [15:0]        in_bone_length,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [23:0] out_joint_x,
  output logic signed [23:0] out_joint_y,
  output logic signed [23:0] out_joint_z,
  output logic signed [15:0] out_joint_qw,
  output logic signed [15:0] out_joint_qx,
  output logic signed [15:0] out_joint_qy,
  output logic signed [15:0] out_joint_qz
);

  localparam int AW = (BONE_SLOTS > 1) ? $clog2(BONE_SLOTS) : 1;
  localparam logic [8:0] SLOTS9 = 9'(BONE_SLOTS);

  // One-hot sequencer states.
  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_EXEC     = 10'b00_0000_0010,
    S_ORI_RD   = 10'b00_0000_0100,
    S_ORI_CHK  = 10'b00_0000_1000,
    S_SOL_RD   = 10'b00_0001_0000,
    S_SOL_PAR  = 10'b00_0010_0000,
    S_SOL_ROT  = 10'b00_0100_0000,
    S_SOL_WAIT = 10'b00_1000_0000,
    S_RD_JNT   = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_t;

  state_t state_r;

  // Captured transaction.
  logic [2:0]       op_r;
  logic [7:0]       idx_r;
  logic [7:0]       cnt_in_r;
  logic [7:0]       par_r;
  logic [7:0]       node_r;
  logic [15:0]      len_r;
  skfk_pkg::quat_t  quat_r;

  // Block state outside the memories.
  logic [7:0]       count_r;
  logic             load_failed_r;
  logic [7:0]       i_r;
  skfk_pkg::quat_t  ori_hold_r;
  logic             rd_cap_r;

  // Pending result and the output register.
  logic [1:0]       status_r;
  skfk_pkg::joint_t jnt_r;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  skfk_pkg::joint_t out_jnt_r;

  // Memory and rotation unit connections.
  logic             mem_clr;
  logic             bone_we;
  skfk_pkg::bone_t  bone_wdata;
  logic [AW-1:0]    bone_raddr;
  skfk_pkg::bone_t  bone_rdata;
  logic             node_we;
  skfk_pkg::quat_t  node_rdata;
  logic             joint_we;
  skfk_pkg::joint_t joint_wdata;
  logic [AW-1:0]    joint_raddr;
  skfk_pkg::joint_t joint_rdata;
  logic             rot_start;
  logic             rot_done;
  skfk_pkg::pos_t   rot_res;

  logic             in_take;
  logic             out_free;
  logic             last_bone;
  logic             is_root;
  logic             load_bad;
  logic [7:0]       read_idx;

  assign in_take  = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign last_bone = ({1'b0, i_r} + 9'd1) >= {1'b0, count_r};
  assign is_root   = (bone_rdata.parent == skfk_pkg::ROOT_MARK) ||
                     (bone_rdata.parent >= i_r);
  // A load is rejected for a slot beyond the table or a parent not earlier.
  assign load_bad  = ({1'b0, idx_r} >= SLOTS9) ||
                     ((par_r != skfk_pkg::ROOT_MARK) && (par_r >= idx_r));
  // Reads past the active bones fall back to the last one, or joint 0.
  assign read_idx  = (idx_r >= count_r) ?
                     ((count_r != 8'd0) ? (count_r - 8'd1) : 8'd0) : idx_r;

  // Memory control follows the sequencer state.
  always_comb begin
    mem_clr              = (state_r == S_EXEC) && (op_r == skfk_pkg::OP_CLEAR);
    bone_we              = (state_r == S_EXEC) && (op_r == skfk_pkg::OP_LOAD) && !load_bad;
    bone_wdata.parent    = par_r;
    bone_wdata.node      = node_r;
    bone_wdata.len       = len_r;
    node_we              = (state_r == S_ORI_CHK) && (bone_rdata.node == node_r);
    bone_raddr           = i_r[AW-1:0];
    joint_raddr          = i_r[AW-1:0];
    joint_we             = 1'b0;
    joint_wdata.q        = node_rdata;
    joint_wdata.p        = '0;
    rot_start            = (state_r == S_SOL_ROT);
    if (state_r == S_SOL_PAR) begin
      // For a child bone the parent index is below the current slot, so it fits.
      bone_raddr  = bone_rdata.parent[AW-1:0];
      joint_raddr = bone_rdata.parent[AW-1:0];
      joint_we    = is_root;
    end
    if (state_r == S_SOL_WAIT) begin
      joint_we      = rot_done;
      joint_wdata.q = ori_hold_r;
      joint_wdata.p = rot_res;
    end
  end

  skfk_bone_mem #(
    .DEPTH (BONE_SLOTS),
    .AW    (AW)
  ) u_bone_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (mem_clr),
    .we    (bone_we),
    .waddr (idx_r[AW-1:0]),
    .wdata (bone_wdata),
    .raddr (bone_raddr),
    .rdata (bone_rdata)
  );

  skfk_pose_mem #(
    .DEPTH (BONE_SLOTS),
    .AW    (AW)
  ) u_pose_mem (
    .clk         (clk),
    .rst_n       (rst_n),
    .clr         (mem_clr),
    .node_we     (node_we),
    .node_waddr  (i_r[AW-1:0]),
    .node_wdata  (quat_r),
    .node_raddr  (i_r[AW-1:0]),
    .node_rdata  (node_rdata),
    .joint_we    (joint_we),
    .joint_waddr (i_r[AW-1:0]),
    .joint_wdata (joint_wdata),
    .joint_raddr (joint_raddr),
    .joint_rdata (joint_rdata)
  );

  // The parent pose and length come back the cycle after S_SOL_PAR.
  skfk_rot u_rot (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rot_start),
    .q     (joint_rdata.q),
    .len   (bone_rdata.len),
    .base  (joint_rdata.p),
    .done  (rot_done),
    .res   (rot_res)
  );

  // Payload capture and the pending result.
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r     <= in_opcode;
      idx_r    <= in_bone_index;
      cnt_in_r <= in_bone_count;
      par_r    <= in_parent_index;
      node_r   <= in_node_id;
      len_r    <= in_bone_length;
      quat_r.w <= in_quat_w;
      quat_r.x <= in_quat_x;
      quat_r.y <= in_quat_y;
      quat_r.z <= in_quat_z;
    end
    if (state_r == S_SOL_PAR) begin
      ori_hold_r <= node_rdata;
    end
    if (state_r == S_EXEC) begin
      jnt_r <= '0;
    end
    if (rd_cap_r) begin
      jnt_r <= joint_rdata;
    end
    if ((state_r == S_DONE) && out_free) begin
      out_status_r <= status_r;
      out_jnt_r    <= jnt_r;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      load_failed_r <= 1'b0;
      i_r           <= '0;
      status_r      <= skfk_pkg::ST_DONE;
      rd_cap_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      rd_cap_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_take) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          status_r <= skfk_pkg::ST_DONE;
          i_r      <= '0;
          state_r  <= S_DONE;
          case (op_r)
            skfk_pkg::OP_CLEAR: begin
              count_r       <= '0;
              load_failed_r <= 1'b0;
            end
            skfk_pkg::OP_LOAD: begin
              if (load_bad) begin
                load_failed_r <= 1'b1;
                status_r      <= skfk_pkg::ST_REJECTED;
              end
            end
            skfk_pkg::OP_COUNT: begin
              if (({1'b0, cnt_in_r} > SLOTS9) || load_failed_r) begin
                status_r <= skfk_pkg::ST_REJECTED;
              end else begin
                count_r <= cnt_in_r;
              end
              load_failed_r <= 1'b0;
            end
            skfk_pkg::OP_ORIENT: begin
              if (count_r == 8'd0) begin
                status_r <= skfk_pkg::ST_NOT_FOUND;
              end else begin
                state_r <= S_ORI_RD;
              end
            end
            skfk_pkg::OP_SOLVE: begin
              if (count_r != 8'd0) begin
                state_r <= S_SOL_RD;
              end
            end
            skfk_pkg::OP_READ: begin
              i_r     <= read_idx;
              state_r <= S_RD_JNT;
            end
            default: begin
              status_r <= skfk_pkg::ST_REJECTED;
            end
          endcase
        end
        S_ORI_RD: begin
          state_r <= S_ORI_CHK;
        end
        S_ORI_CHK: begin
          // The first active bone carrying the node id takes the update.
          if (bone_rdata.node == node_r) begin
            state_r <= S_DONE;
          end else if (last_bone) begin
            status_r <= skfk_pkg::ST_NOT_FOUND;
            state_r  <= S_DONE;
          end else begin
            i_r     <= i_r + 8'd1;
            state_r <= S_ORI_RD;
          end
        end
        S_SOL_RD: begin
          state_r <= S_SOL_PAR;
        end
        S_SOL_PAR: begin
          if (!is_root) begin
            state_r <= S_SOL_ROT;
          end else if (last_bone) begin
            state_r <= S_DONE;
          end else begin
            i_r     <= i_r + 8'd1;
            state_r <= S_SOL_RD;
          end
        end
        S_SOL_ROT: begin
          state_r <= S_SOL_WAIT;
        end
        S_SOL_WAIT: begin
          if (rot_done) begin
            if (last_bone) begin
              state_r <= S_DONE;
            end else begin
              i_r     <= i_r + 8'd1;
              state_r <= S_SOL_RD;
            end
          end
        end
        S_RD_JNT: begin
          rd_cap_r <= 1'b1;
          state_r  <= S_DONE;
        end
        S_DONE: begin
          // rd_cap_r lands the read data in jnt_r during the first cycle in this state.
          if (out_free && !rd_cap_r) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_joint_x  = out_jnt_r.p.x;
  assign out_joint_y  = out_jnt_r.p.y;
  assign out_joint_z  = out_jnt_r.p.z;
  assign out_joint_qw = out_jnt_r.q.w;
  assign out_joint_qx = out_jnt_r.q.x;
  assign out_joint_qy = out_jnt_r.q.y;
  assign out_joint_qz = out_jnt_r.q.z;

endmodule

>>> src/skfk_bone_mem.sv
// ----------------------------------------------------------------------------
// skfk_bone_mem
// Bone table memory (parent, node id, length) with per-entry valid bits.
// ----------------------------------------------------------------------------
module skfk_bone_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            clr,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  skfk_pkg::bone_t wdata,
  input  logic [AW-1:0]   raddr,
  output skfk_pkg::bone_t rdata
);

  skfk_pkg::bone_t  mem [DEPTH];
  skfk_pkg::bone_t  q_r;
  logic             q_vld_r;
  logic [DEPTH-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      q_vld_r <= vld_r[raddr];
      if (clr) begin
        vld_r <= '0;
      end else if (we) begin
        vld_r[waddr] <= 1'b1;
      end
    end
  end

  // Entries never written since the last clear read as zero.
  assign rdata = q_vld_r ? q_r : '0;

endmodule

>>> src/skfk_pose_mem.sv
// ----------------------------------------------------------------------------
// skfk_pose_mem
// Node orientation memory and solved joint pose memory with valid bits.
// ----------------------------------------------------------------------------
module skfk_pose_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic             node_we,
  input  logic [AW-1:0]    node_waddr,
  input  skfk_pkg::quat_t  node_wdata,
  input  logic [AW-1:0]    node_raddr,
  output skfk_pkg::quat_t  node_rdata,
  input  logic             joint_we,
  input  logic [AW-1:0]    joint_waddr,
  input  skfk_pkg::joint_t joint_wdata,
  input  logic [AW-1:0]    joint_raddr,
  output skfk_pkg::joint_t joint_rdata
);

  skfk_pkg::quat_t  node_mem [DEPTH];
  skfk_pkg::joint_t joint_mem [DEPTH];
  skfk_pkg::quat_t  node_q_r;
  skfk_pkg::joint_t joint_q_r;
  logic             node_q_vld_r;
  logic             joint_q_vld_r;
  logic [DEPTH-1:0] node_vld_r;
  logic [DEPTH-1:0] joint_vld_r;
  skfk_pkg::quat_t  ident;

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (joint_we) begin
      joint_mem[joint_waddr] <= joint_wdata;
    end
    node_q_r  <= node_mem[node_raddr];
    joint_q_r <= joint_mem[joint_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_vld_r    <= '0;
      joint_vld_r   <= '0;
      node_q_vld_r  <= 1'b0;
      joint_q_vld_r <= 1'b0;
    end else begin
      node_q_vld_r  <= node_vld_r[node_raddr];
      joint_q_vld_r <= joint_vld_r[joint_raddr];
      if (clr) begin
        node_vld_r  <= '0;
        joint_vld_r <= '0;
      end else begin
        if (node_we) begin
          node_vld_r[node_waddr] <= 1'b1;
        end
        if (joint_we) begin
          joint_vld_r[joint_waddr] <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    ident   = '0;
    ident.w = skfk_pkg::Q_ONE;
  end

  // Unwritten orientations read as identity, unwritten joints as zero.
  assign node_rdata  = node_q_vld_r ? node_q_r : ident;
  assign joint_rdata = joint_q_vld_r ? joint_q_r : '0;

endmodule

>>> src/skfk_rot.sv
// ----------------------------------------------------------------------------
// skfk_rot
// Rotates (0, L, 0) by a quaternion and adds it to a position, one axis at a
// time over three stages per axis.
// ----------------------------------------------------------------------------
module skfk_rot (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  skfk_pkg::quat_t  q,
  input  logic [15:0]      len,
  input  skfk_pkg::pos_t   base,
  output logic             done,
  output skfk_pkg::pos_t   res
);

  localparam logic signed [33:0] ONE_Q28  = 34'sh1000_0000;
  localparam logic signed [50:0] HALF_Q28 = 51'sh800_0000;
  localparam logic signed [25:0] POS_MAX  = 26'sd8388607;
  localparam logic signed [25:0] POS_MIN  = -26'sd8388608;

  skfk_pkg::quat_t    q_r;
  logic [15:0]        len_r;
  logic signed [23:0] base_r [3];
  logic signed [23:0] res_r  [3];
  logic signed [33:0] a_r;
  logic signed [50:0] prod_r;
  logic [1:0]         comp_r;
  logic [1:0]         ph_r;
  logic               busy_r;
  logic               done_r;

  logic signed [31:0] m1, m2;
  logic signed [33:0] a_nxt;
  logic signed [50:0] t;
  logic signed [25:0] sum;
  logic signed [23:0] sat;

  always_comb begin
    case (comp_r)
      2'd0: begin
        m1    = q_r.x * q_r.y;
        m2    = q_r.w * q_r.z;
        a_nxt = (34'(m1) - 34'(m2)) <<< 1;
      end
      2'd1: begin
        m1    = q_r.x * q_r.x;
        m2    = q_r.z * q_r.z;
        a_nxt = ONE_Q28 - ((34'(m1) + 34'(m2)) <<< 1);
      end
      default: begin
        m1    = q_r.w * q_r.x;
        m2    = q_r.y * q_r.z;
        a_nxt = (34'(m1) + 34'(m2)) <<< 1;
      end
    endcase
    // Round half up at 2^-28, then saturate the sum to 24 bits.
    t   = prod_r + HALF_Q28;
    sum = 26'(base_r[comp_r]) + 26'($signed(t[50:28]));
    if (sum > POS_MAX) begin
      sat = 24'(POS_MAX);
    end else if (sum < POS_MIN) begin
      sat = 24'(POS_MIN);
    end else begin
      sat = sum[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r       <= q;
      len_r     <= len;
      base_r[0] <= base.x;
      base_r[1] <= base.y;
      base_r[2] <= base.z;
    end
    if (busy_r) begin
      case (ph_r)
        2'd0:    a_r    <= a_nxt;
        2'd1:    prod_r <= 51'(a_r) * 51'($signed({1'b0, len_r}));
        default: res_r[comp_r] <= sat;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      comp_r <= '0;
      ph_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        comp_r <= '0;
        ph_r   <= '0;
      end else if (busy_r) begin
        if (ph_r == 2'd2) begin
          ph_r <= '0;
          if (comp_r == 2'd2) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            comp_r <= comp_r + 2'd1;
          end
        end else begin
          ph_r <= ph_r + 2'd1;
        end
      end
    end
  end

  assign done  = done_r;
  assign res.x = res_r[0];
  assign res.y = res_r[1];
  assign res.z = res_r[2];

endmodule
